// ===== src/lprt_pkg.sv =====
// shared types, constants and helpers for the longest-prefix route table
package lprt_pkg;

  localparam int ADDR_W         = 32;
  localparam int LEN_W          = 6;
  localparam int IFACE_W        = 4;
  localparam int TTL_W          = 8;
  localparam int FULL_LEN       = 32;
  localparam int MAX_ROUTES_DEF = 16;
  localparam int NUM_IFACES_DEF = 16;

  typedef enum logic [2:0] {
    ST_FORWARD  = 3'd0,
    ST_TTL_DROP = 3'd1,
    ST_NO_ROUTE = 3'd2,
    ST_ADDED    = 3'd3,
    ST_FULL     = 3'd4,
    ST_BAD_LEN  = 3'd5
  } status_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_ROUTE = 1'b1
  } opcode_t;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               hop_vld;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
  } route_t;

  // search request walking down the cell row, carrying the best match so far
  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  dst;
    logic               found;
    logic [LEN_W-1:0]   best_len;
    logic [IFACE_W-1:0] iface;
    logic [ADDR_W-1:0]  addr;
  } lookup_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

// ===== src/lprt_cell.sv =====
// one route cell: holds a route and updates the passing lookup request
module lprt_cell
  import lprt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  route_t  wr_entry,
  input  logic    live,
  input  logic    hold,
  input  lookup_t tok_i,
  output lookup_t tok_o
);

  route_t  entry_r;
  lookup_t tok_r;
  lookup_t tok_nxt;
  logic    hit;
  logic    take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  always_comb begin
    hit  = live && (((entry_r.prefix ^ tok_i.dst) & len_mask(entry_r.len)) == '0);
    take = hit && (!tok_i.found || (entry_r.len > tok_i.best_len));
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best_len = entry_r.len;
      tok_nxt.iface    = entry_r.iface;
      tok_nxt.addr     = entry_r.hop_vld ? entry_r.hop : tok_i.dst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (!hold) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== src/longest_prefix_route_table.sv =====
// top level: route table built as a row of route cells with result register
// order: an add or ttl drop goes to the status register, then the result register; a
// lookup walks every cell, the first loading on the accepting edge, then the result register
// flow: one request at a time; next accepted the cycle after its result is registered;
// out_ready low holds the row
// reset (rst_n low, synchronous) empties the table; stored routes need no clearing
module longest_prefix_route_table
  import lprt_pkg::*;
#(
  parameter int MAX_ROUTES = MAX_ROUTES_DEF,
  parameter int NUM_IFACES = NUM_IFACES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [ADDR_W-1:0]   in_route_prefix,
  input  logic [LEN_W-1:0]    in_prefix_len,
  input  logic                in_hop_present,
  input  logic [ADDR_W-1:0]   in_hop_address,
  input  logic [IFACE_W-1:0]  in_out_interface,
  input  logic [ADDR_W-1:0]   in_dest_address,
  input  logic [TTL_W-1:0]    in_ttl_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [IFACE_W-1:0]  out_send_interface,
  output logic [ADDR_W-1:0]   out_send_address,
  output logic [TTL_W-1:0]    out_ttl_out
);

  localparam int CNT_W = $clog2(MAX_ROUTES + 1);
  localparam int IFC_W = IFACE_W + 5;

  logic             acc;
  logic             is_add;
  logic             bad_len;
  logic             full;
  logic             do_write;
  logic             launch;
  logic             out_free;
  logic             load_imm;
  logic             load_tok;
  logic             hold;
  route_t           wr_entry;
  lookup_t          tok_w [0:MAX_ROUTES];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             imm_vld_r, imm_vld_nxt;
  status_t          imm_status_r, imm_status_nxt;
  logic [TTL_W-1:0] ttl_r;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [IFACE_W-1:0] out_iface_r, out_iface_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [TTL_W-1:0]   out_ttl_r, out_ttl_nxt;

  assign in_ready = !busy_r;
  assign acc      = in_valid && in_ready;
  assign is_add   = (in_opcode == OP_ADD);
  assign bad_len  = (in_prefix_len > LEN_W'(FULL_LEN));
  assign full     = (cnt_r == CNT_W'(MAX_ROUTES));
  assign do_write = acc && is_add && !bad_len && !full;
  assign launch   = acc && !is_add && (in_ttl_in > TTL_W'(1));

  assign out_free = !out_valid_r || out_ready;
  assign load_imm = imm_vld_r && out_free;
  assign load_tok = tok_w[MAX_ROUTES].vld && out_free;
  assign hold     = tok_w[MAX_ROUTES].vld && !out_free;

  always_comb begin
    wr_entry.prefix  = in_route_prefix;
    wr_entry.len     = in_prefix_len;
    wr_entry.hop_vld = in_hop_present;
    wr_entry.hop     = in_hop_address;
    if (IFC_W'(in_out_interface) >= IFC_W'(NUM_IFACES)) begin
      wr_entry.iface = IFACE_W'(NUM_IFACES - 1);
    end else begin
      wr_entry.iface = in_out_interface;
    end
  end

  assign tok_w[0] = '{vld: launch, dst: in_dest_address, default: '0};

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    lprt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (do_write && (cnt_r == CNT_W'(i))),
      .wr_entry (wr_entry),
      .live     (cnt_r > CNT_W'(i)),
      .hold     (hold),
      .tok_i    (tok_w[i]),
      .tok_o    (tok_w[i+1])
    );
  end

  always_comb begin
    cnt_nxt        = do_write ? cnt_r + CNT_W'(1) : cnt_r;
    busy_nxt       = busy_r;
    imm_vld_nxt    = imm_vld_r;
    imm_status_nxt = imm_status_r;
    if (load_imm || load_tok) begin
      busy_nxt    = 1'b0;
      imm_vld_nxt = 1'b0;
    end
    if (acc) begin
      busy_nxt = 1'b1;
      if (is_add) begin
        imm_vld_nxt = 1'b1;
        if (bad_len) begin
          imm_status_nxt = ST_BAD_LEN;
        end else if (full) begin
          imm_status_nxt = ST_FULL;
        end else begin
          imm_status_nxt = ST_ADDED;
        end
      end else if (!launch) begin
        imm_vld_nxt    = 1'b1;
        imm_status_nxt = ST_TTL_DROP;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_iface_nxt  = out_iface_r;
    out_addr_nxt   = out_addr_r;
    out_ttl_nxt    = out_ttl_r;
    if (load_imm) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = imm_status_r;
      out_iface_nxt  = '0;
      out_addr_nxt   = '0;
      out_ttl_nxt    = '0;
    end else if (load_tok) begin
      out_valid_nxt = 1'b1;
      if (tok_w[MAX_ROUTES].found) begin
        out_status_nxt = ST_FORWARD;
        out_iface_nxt  = tok_w[MAX_ROUTES].iface;
        out_addr_nxt   = tok_w[MAX_ROUTES].addr;
        out_ttl_nxt    = ttl_r - TTL_W'(1);
      end else begin
        out_status_nxt = ST_NO_ROUTE;
        out_iface_nxt  = '0;
        out_addr_nxt   = '0;
        out_ttl_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      imm_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      imm_vld_r   <= imm_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    imm_status_r <= imm_status_nxt;
    out_status_r <= out_status_nxt;
    out_iface_r  <= out_iface_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ttl_r    <= out_ttl_nxt;
    if (acc) begin
      ttl_r <= in_ttl_in;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_send_interface = out_iface_r;
  assign out_send_address   = out_addr_r;
  assign out_ttl_out        = out_ttl_r;

`ifndef ASSERT_OFF
  a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[MAX_ROUTES].vld |-> busy_r)
    else $error("lookup in flight without busy");

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(imm_vld_r && tok_w[MAX_ROUTES].vld))
    else $error("two results pending at once");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ROUTES))
    else $error("route count beyond table size");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_imm || load_tok) |=> (!busy_r && out_valid_r))
    else $error("result load did not release request");
`endif

endmodule

// ===== tb/sv/tb_longest_prefix_route_table.sv =====
// testbench for longest_prefix_route_table: directed table, random requests, scoreboard
module tb_longest_prefix_route_table
  import lprt_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS = 18;
  localparam int N_RANDOM = 1032;

  typedef struct packed {
    opcode_t            op;
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               hop_vld;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
    logic [ADDR_W-1:0]  dst;
    logic [TTL_W-1:0]   ttl;
  } route_req_t;

  typedef struct packed {
    status_t            status;
    logic [IFACE_W-1:0] iface;
    logic [ADDR_W-1:0]  addr;
    logic [TTL_W-1:0]   ttl;
  } route_res_t;

  typedef struct packed {
    route_req_t req;
    logic       fixed;
    route_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = 1'b0;
  logic [ADDR_W-1:0] in_route_prefix = '0;
  logic [LEN_W-1:0] in_prefix_len = '0;
  logic in_hop_present = 1'b0;
  logic [ADDR_W-1:0] in_hop_address = '0;
  logic [IFACE_W-1:0] in_out_interface = '0;
  logic [ADDR_W-1:0] in_dest_address = '0;
  logic [TTL_W-1:0] in_ttl_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [IFACE_W-1:0] out_send_interface;
  logic [ADDR_W-1:0] out_send_address;
  logic [TTL_W-1:0] out_ttl_out;

  longest_prefix_route_table #(
    .MAX_ROUTES(MAX_ROUTES_DEF),
    .NUM_IFACES(NUM_IFACES_DEF)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_route_prefix    (in_route_prefix),
    .in_prefix_len      (in_prefix_len),
    .in_hop_present     (in_hop_present),
    .in_hop_address     (in_hop_address),
    .in_out_interface   (in_out_interface),
    .in_dest_address    (in_dest_address),
    .in_ttl_in          (in_ttl_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_send_interface (out_send_interface),
    .out_send_address   (out_send_address),
    .out_ttl_out        (out_ttl_out)
  );

  always #5 clk = ~clk;

  // routing table as the testbench sees it
  logic [ADDR_W-1:0]  tbl_prefix [MAX_ROUTES_DEF];
  logic [LEN_W-1:0]   tbl_len [MAX_ROUTES_DEF];
  logic               tbl_hop_vld [MAX_ROUTES_DEF];
  logic [ADDR_W-1:0]  tbl_hop [MAX_ROUTES_DEF];
  logic [IFACE_W-1:0] tbl_iface [MAX_ROUTES_DEF];
  int tbl_count = 0;

  route_res_t result_q [$];
  int err_cnt = 0;
  int n_sent = 0;
  int status_seen [8];

  localparam route_res_t NO_RES = '{ST_FORWARD, 4'd0, 32'd0, 8'd0};

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h0000_0000, 8'd5},
      1'b1, '{ST_NO_ROUTE, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h0A01_0203, 8'd0},
      1'b1, '{ST_TTL_DROP, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h0A01_0203, 8'd1},
      1'b1, '{ST_TTL_DROP, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ADD, 32'h0A00_0000, 6'd33, 1'b1, 32'h1, 4'd1, 32'h0, 8'd0},
      1'b1, '{ST_BAD_LEN, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ADD, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15, 32'h0, 8'd0},
      1'b1, '{ST_BAD_LEN, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ADD, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd15, 32'h0, 8'd0},
      1'b1, '{ST_ADDED, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'hFFFF_FFFF, 8'd255},
      1'b1, '{ST_FORWARD, 4'd15, 32'hFFFF_FFFF, 8'd254}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'hFFFF_FFFE, 8'd2},
      1'b1, '{ST_NO_ROUTE, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ADD, 32'h0A00_0000, 6'd8, 1'b0, 32'h0, 4'd1, 32'h0, 8'd0},
      1'b1, '{ST_ADDED, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ADD, 32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 4'd2, 32'h0, 8'd0},
      1'b1, '{ST_ADDED, 4'd0, 32'd0, 8'd0}},
    // same prefix and length: the earlier entry must keep winning
    '{'{OP_ADD, 32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0002, 4'd3, 32'h0, 8'd0},
      1'b1, '{ST_ADDED, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h0A01_0203, 8'd64},
      1'b0, NO_RES},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h0A02_0304, 8'd64},
      1'b0, NO_RES},
    '{'{OP_ADD, 32'h0A01_0203, 6'd32, 1'b0, 32'h0, 4'd4, 32'h0, 8'd0},
      1'b1, '{ST_ADDED, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h0A01_0203, 8'd128},
      1'b0, NO_RES},
    // add fields set on a lookup are ignored
    '{'{OP_ROUTE, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15, 32'h0B00_0000, 8'd2},
      1'b1, '{ST_NO_ROUTE, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ADD, 32'h8000_0000, 6'd1, 1'b1, 32'h0, 4'd0, 32'hFFFF_FFFF, 8'd255},
      1'b1, '{ST_ADDED, 4'd0, 32'd0, 8'd0}},
    '{'{OP_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 4'd0, 32'h8000_0001, 8'd3},
      1'b0, NO_RES}
  };

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (FULL_LEN - len);
  endfunction

  function automatic route_res_t route_table_predict(input route_req_t rq);
    route_res_t res;
    logic [ADDR_W-1:0] m;
    logic found;
    int best;
    logic [LEN_W-1:0] best_len;
    res = '0;
    found = 1'b0;
    best = 0;
    best_len = '0;
    if (rq.op == OP_ADD) begin
      if (rq.len > FULL_LEN) begin
        res.status = ST_BAD_LEN;
      end else if (tbl_count >= MAX_ROUTES_DEF) begin
        res.status = ST_FULL;
      end else begin
        tbl_prefix[tbl_count] = rq.prefix;
        tbl_len[tbl_count] = rq.len;
        tbl_hop_vld[tbl_count] = rq.hop_vld;
        tbl_hop[tbl_count] = rq.hop;
        tbl_iface[tbl_count] = (rq.iface >= NUM_IFACES_DEF) ?
                               IFACE_W'(NUM_IFACES_DEF - 1) : rq.iface;
        tbl_count++;
        res.status = ST_ADDED;
      end
    end else if (rq.ttl <= 1) begin
      res.status = ST_TTL_DROP;
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        m = prefix_mask(tbl_len[i]);
        if (((tbl_prefix[i] ^ rq.dst) & m) == '0 && (!found || tbl_len[i] > best_len)) begin
          found = 1'b1;
          best = i;
          best_len = tbl_len[i];
        end
      end
      if (!found) begin
        res.status = ST_NO_ROUTE;
      end else begin
        res.status = ST_FORWARD;
        res.iface = tbl_iface[best];
        res.addr = tbl_hop_vld[best] ? tbl_hop[best] : rq.dst;
        res.ttl = rq.ttl - 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input route_req_t rq, input logic fixed, input route_res_t typed);
    route_res_t pred;
    in_opcode <= rq.op;
    in_route_prefix <= rq.prefix;
    in_prefix_len <= rq.len;
    in_hop_present <= rq.hop_vld;
    in_hop_address <= rq.hop;
    in_out_interface <= rq.iface;
    in_dest_address <= rq.dst;
    in_ttl_in <= rq.ttl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = route_table_predict(rq);
    result_q.insert(result_q.size(), fixed ? typed : pred);
    n_sent++;
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  always @(posedge clk) begin : result_check
    route_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_status < 8) status_seen[out_status]++;
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d", out_status);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_cnt++;
        end
        if (out_send_interface !== want.iface) begin
          $error("send_interface: expected %0d, got %0d", want.iface, out_send_interface);
          err_cnt++;
        end
        if (out_send_address !== want.addr) begin
          $error("send_address: expected %08h, got %08h", want.addr, out_send_address);
          err_cnt++;
        end
        if (out_ttl_out !== want.ttl) begin
          $error("ttl_out: expected %0d, got %0d", want.ttl, out_ttl_out);
          err_cnt++;
        end
      end
    end
  end

  initial begin : sink_stall
    int n;
    int busy;
    repeat (11) @(posedge clk);
    forever begin
      n = pick_gap();
      busy = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (busy) @(posedge clk);
    end
  end

  initial begin : stimulus
    route_req_t rq;
    logic [ADDR_W-1:0] m;
    int idx;
    int r;
    logic copied;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_tbl[i].req, dir_tbl[i].fixed, dir_tbl[i].res);
      idle_sender(pick_gap());
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) drain_results();
      rq.prefix = $urandom;
      rq.len = LEN_W'($urandom);
      rq.hop_vld = 1'($urandom);
      rq.hop = $urandom;
      rq.iface = IFACE_W'($urandom);
      rq.dst = $urandom;
      rq.ttl = TTL_W'($urandom);
      r = $urandom_range(0, 99);
      rq.op = (r < ((tbl_count < MAX_ROUTES_DEF) ? 40 : 15)) ? OP_ADD : OP_ROUTE;
      idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
      r = $urandom_range(0, 99);
      if (rq.op == OP_ADD) begin
        copied = (tbl_count > 0) && $urandom_range(0, 1);
        if (copied) rq.prefix = tbl_prefix[idx];
        if (r < 8) rq.len = LEN_W'($urandom_range(33, 63));
        else if (tbl_count == MAX_ROUTES_DEF - 1 && r < 60) rq.len = '0;
        else if (copied && r < 30) rq.len = tbl_len[idx];
        else rq.len = LEN_W'($urandom_range(1, 32));
      end else begin
        if (tbl_count > 0 && r < 70) begin
          m = prefix_mask(tbl_len[idx]);
          rq.dst = (tbl_prefix[idx] & m) | (rq.dst & ~m);
        end
        r = $urandom_range(0, 99);
        if (r < 10) rq.ttl = TTL_W'($urandom_range(0, 1));
        else if (r < 15) rq.ttl = 8'd255;
        else rq.ttl = TTL_W'($urandom_range(2, 255));
      end
      send_request(rq, 1'b0, NO_RES);
      idle_sender(pick_gap());
    end
    drain_results();
    repeat (MAX_ROUTES_DEF + 4) @(posedge clk);
    $display("summary: %0d requests, %0d routes stored, %0d forwarded, %0d ttl drops",
             n_sent, tbl_count, status_seen[ST_FORWARD], status_seen[ST_TTL_DROP]);
    $display("summary: %0d no route, %0d added, %0d table full, %0d bad length",
             status_seen[ST_NO_ROUTE], status_seen[ST_ADDED], status_seen[ST_FULL],
             status_seen[ST_BAD_LEN]);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("tb_longest_prefix_route_table: done, clean");
    end else begin
      $display("tb_longest_prefix_route_table: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("tb_longest_prefix_route_table: done, errors");
    $finish;
  end

endmodule
